>>> design/scp_pkg.sv
// ----------------------------------------------------------------------------
// scp_pkg
// shared constants, types and range tables of the servo command line parser
// ----------------------------------------------------------------------------
package scp_pkg;

  localparam int BUFFER_BYTES = 256;
  localparam int CNT_W        = $clog2(BUFFER_BYTES);
  localparam int NUM_FIELDS   = 6;
  localparam int MAG_W        = 10;
  localparam int ACC_W        = MAG_W + 4;

  localparam logic [MAG_W-1:0] MAG_MAX = '1;

  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_COMMA = 8'd44;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;

  localparam logic [1:0] PH_SKIP   = 2'd0;
  localparam logic [1:0] PH_SIGN   = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  localparam logic [1:0] ST_MOVE     = 2'd0;
  localparam logic [1:0] ST_NODIGITS = 2'd1;
  localparam logic [1:0] ST_NOCOMMA  = 2'd2;
  localparam logic [1:0] ST_RANGE    = 2'd3;

  localparam logic [2:0] LAST_FIELD = 3'd5;

  typedef logic [NUM_FIELDS-1:0][7:0] angle_arr_t;

  typedef struct packed {
    logic [1:0] status;
    angle_arr_t angle;
  } result_t;

  function automatic logic [MAG_W-1:0] lim_low(input logic [2:0] k);
    logic [MAG_W-1:0] v;
    case (k)
      3'd1:    v = MAG_W'(15);
      3'd5:    v = MAG_W'(10);
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [MAG_W-1:0] lim_high(input logic [2:0] k);
    logic [MAG_W-1:0] v;
    case (k)
      3'd1:    v = MAG_W'(165);
      3'd5:    v = MAG_W'(73);
      default: v = MAG_W'(180);
    endcase
    return v;
  endfunction

  function automatic logic out_of_range(input logic [2:0] k, input logic neg,
                                        input logic [MAG_W-1:0] mag);
    return (neg && (mag != '0)) || (mag < lim_low(k)) || (mag > lim_high(k));
  endfunction

endpackage

>>> design/scp_in_stage.sv
// ----------------------------------------------------------------------------
// scp_in_stage
// input register for received bytes
// ----------------------------------------------------------------------------
module scp_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       take,
  output logic       byte_valid,
  output logic [7:0] byte_data
);
  import scp_pkg::*;

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;

  assign in_ready  = !valid_r || take;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_rx_byte;
    end
  end

  assign byte_valid = valid_r;
  assign byte_data  = byte_r;

endmodule

>>> design/scp_parser.sv
// ----------------------------------------------------------------------------
// scp_parser
// per-byte line parse state, angle store and end-of-line result
// ----------------------------------------------------------------------------
module scp_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [7:0]            byte_data,
  input  logic                  step,
  output logic                  finish,
  output scp_pkg::result_t      result
);
  import scp_pkg::*;

  logic [2:0]       field_r, field_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic             neg_r, neg_nxt;
  logic [MAG_W-1:0] mag_r, mag_nxt;
  logic [1:0]       err_r, err_nxt;
  logic             rbad_r, rbad_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  angle_arr_t       angle_r;

  logic             st_en;
  logic [2:0]       st_idx;
  logic [7:0]       st_val;
  logic             st_neg;
  logic [MAG_W-1:0] st_mag;
  logic             is_space, is_digit;
  logic [ACC_W-1:0] acc;
  angle_arr_t       angle_eff;

  // error and range flags before the end-of-line clear
  logic [1:0]       err_line;
  logic             rbad_line;
  logic [1:0]       line_status;

  assign is_space = (byte_data == CH_SPACE) || (byte_data >= CH_TAB && byte_data <= CH_CR);
  assign is_digit = (byte_data >= CH_ZERO) && (byte_data <= CH_NINE);
  assign acc      = ACC_W'(mag_r) * ACC_W'(10) + ACC_W'(byte_data[3:0]);

  always_comb begin
    field_nxt = field_r;
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    mag_nxt   = mag_r;
    err_nxt   = err_r;
    rbad_nxt  = rbad_r;
    cnt_nxt   = cnt_r;
    st_en     = 1'b0;
    st_idx    = field_r;
    st_val    = mag_r[7:0];
    st_neg    = neg_r;
    st_mag    = mag_r;
    finish    = 1'b0;

    if (byte_data == CH_LF) begin
      finish = 1'b1;
    end else begin
      if (phase_r != PH_DONE) begin
        if (byte_data == CH_NUL) begin
          // end of string seen by the parser
          if (phase_r == PH_DIGITS) begin
            st_en = 1'b1;
            if (field_r < LAST_FIELD) begin
              err_nxt = ST_NOCOMMA;
            end
          end else begin
            err_nxt = ST_NODIGITS;
          end
          phase_nxt = PH_DONE;
        end else if (phase_r == PH_SKIP && is_space) begin
          phase_nxt = PH_SKIP;
        end else if (phase_r == PH_SKIP && (byte_data == CH_PLUS || byte_data == CH_MINUS)) begin
          neg_nxt   = (byte_data == CH_MINUS);
          phase_nxt = PH_SIGN;
        end else if (phase_r == PH_SKIP || phase_r == PH_SIGN) begin
          if (is_digit) begin
            mag_nxt   = MAG_W'(byte_data[3:0]);
            phase_nxt = PH_DIGITS;
          end else begin
            err_nxt   = ST_NODIGITS;
            phase_nxt = PH_DONE;
          end
        end else if (is_digit) begin
          mag_nxt = (acc > ACC_W'(MAG_MAX)) ? MAG_MAX : acc[MAG_W-1:0];
        end else begin
          st_en = 1'b1;
          if (field_r >= LAST_FIELD) begin
            phase_nxt = PH_DONE;
          end else if (byte_data == CH_COMMA) begin
            field_nxt = field_r + 3'd1;
            phase_nxt = PH_SKIP;
            neg_nxt   = 1'b0;
            mag_nxt   = '0;
          end else begin
            err_nxt   = ST_NOCOMMA;
            phase_nxt = PH_DONE;
          end
        end
      end
      cnt_nxt = cnt_r + CNT_W'(1);
      finish  = (cnt_nxt == CNT_W'(BUFFER_BYTES - 1));
    end

    // line end closes an unfinished field
    if (finish && phase_nxt != PH_DONE) begin
      if (phase_nxt == PH_DIGITS) begin
        st_en  = 1'b1;
        st_idx = field_nxt;
        st_neg = neg_nxt;
        st_mag = mag_nxt;
        if (field_nxt < LAST_FIELD) begin
          err_nxt = ST_NOCOMMA;
        end
      end else begin
        err_nxt = ST_NODIGITS;
      end
      phase_nxt = PH_DONE;
    end

    if (st_en) begin
      st_val = st_mag[7:0];
      if (out_of_range(st_idx, st_neg, st_mag)) begin
        rbad_nxt = 1'b1;
      end
    end

    err_line  = err_nxt;
    rbad_line = rbad_nxt;

    if (finish) begin
      field_nxt = '0;
      phase_nxt = PH_SKIP;
      neg_nxt   = 1'b0;
      mag_nxt   = '0;
      err_nxt   = ST_MOVE;
      rbad_nxt  = 1'b0;
      cnt_nxt   = '0;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_FIELDS; i++) begin
      angle_eff[i] = (st_en && st_idx == 3'(i)) ? st_val : angle_r[i];
    end
  end

  always_comb begin
    line_status = err_line;
    if (err_line == ST_MOVE && rbad_line) begin
      line_status = ST_RANGE;
    end
    result.status = line_status;
    for (int i = 0; i < NUM_FIELDS; i++) begin
      result.angle[i] = (line_status == ST_MOVE) ? angle_eff[i] : 8'd0;
    end
    result.angle[NUM_FIELDS-1][7] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_r <= '0;
      phase_r <= PH_SKIP;
      neg_r   <= 1'b0;
      mag_r   <= '0;
      err_r   <= ST_MOVE;
      rbad_r  <= 1'b0;
      cnt_r   <= '0;
    end else if (step) begin
      field_r <= field_nxt;
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      mag_r   <= mag_nxt;
      err_r   <= err_nxt;
      rbad_r  <= rbad_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && st_en) begin
      angle_r[st_idx] <= st_val;
    end
  end

endmodule

>>> design/scp_out_stage.sv
// ----------------------------------------------------------------------------
// scp_out_stage
// result register toward the command consumer
// ----------------------------------------------------------------------------
module scp_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  scp_pkg::result_t result,
  output logic             slot_free,
  output logic             out_valid,
  input  logic             out_ready,
  output scp_pkg::result_t out_result
);
  import scp_pkg::*;

  logic    valid_r, valid_nxt;
  result_t result_r;

  assign slot_free = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;

endmodule

>>> design/servo_command_line_parser_core.sv
// result path: the line-end byte passes the input register, then its result is loaded into the output register
// throughput: one byte per cycle; a byte that closes a line waits while an untaken result is held
// a line closes at a newline or after BUFFER_BYTES-1 bytes, one result per line
// the output register holds a result while the next byte is taken
// reset (rst_n low, synchronous) empties both stages and starts a fresh line
// ----------------------------------------------------------------------------
// servo_command_line_parser_core
// parses comma-separated joint angle lines into move commands
// ----------------------------------------------------------------------------
module servo_command_line_parser_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_status,
  output logic [7:0] out_base_angle,
  output logic [7:0] out_shoulder_angle,
  output logic [7:0] out_elbow_angle,
  output logic [7:0] out_wrist_tilt_angle,
  output logic [7:0] out_wrist_turn_angle,
  output logic [6:0] out_grip_angle
);
  import scp_pkg::*;

  logic       byte_valid;
  logic [7:0] byte_data;
  logic       finish;
  logic       slot_free;
  logic       step;
  result_t    result;
  result_t    out_result;

  assign step = byte_valid && (!finish || slot_free);

  scp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .take       (step),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  scp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_data (byte_data),
    .step      (step),
    .finish    (finish),
    .result    (result)
  );

  scp_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step && finish),
    .result     (result),
    .slot_free  (slot_free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_result (out_result)
  );

  assign out_status           = out_result.status;
  assign out_base_angle       = out_result.angle[0];
  assign out_shoulder_angle   = out_result.angle[1];
  assign out_elbow_angle      = out_result.angle[2];
  assign out_wrist_tilt_angle = out_result.angle[3];
  assign out_wrist_turn_angle = out_result.angle[4];
  assign out_grip_angle       = out_result.angle[5][6:0];

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !(step && finish))
    else $error("result overwritten while held");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_MOVE) |->
      (out_base_angle == 8'd0 && out_shoulder_angle == 8'd0 && out_elbow_angle == 8'd0
       && out_wrist_tilt_angle == 8'd0 && out_wrist_turn_angle == 8'd0
       && out_grip_angle == 7'd0))
    else $error("angles not cleared on error status");

  a_move_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_MOVE) |->
      (out_shoulder_angle >= 8'd15 && out_shoulder_angle <= 8'd165
       && out_grip_angle >= 7'd10 && out_grip_angle <= 7'd73
       && out_base_angle <= 8'd180))
    else $error("move command angle out of range");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (byte_valid && !step) |=> byte_valid)
    else $error("pending byte dropped");
`endif

endmodule
